FILE: src/hpf_pkg.sv
// ---------------------------------------------------------------------------
// hpf_pkg
// Shared types and constants of the heatmap peak finder: field widths,
// configuration register indexes and the controller/datapath interface.
// ---------------------------------------------------------------------------
package hpf_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int COORD_W    = 6;
  localparam int COUNT_W    = 6;
  localparam int WINSZ_W    = 4;
  localparam int HALF_W     = 3;
  localparam int DIM_CFG_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEAKS   = 3'd4;

  // reset values of the registers
  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd410;
  localparam logic [WINSZ_W-1:0]         WINDOW_RST    = 4'd5;
  localparam logic [DIM_CFG_W-1:0]       DIM_RST       = 7'd64;
  localparam logic [COUNT_W-1:0]         PEAKS_RST     = 6'd32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;          // store the accepted sample
    logic scan_start;    // clear pixel counters and peak count
    logic pix_setup;     // read the centre, work out the window bounds
    logic center_cap;    // capture the centre value
    logic win_issue;     // read the next window sample
    logic emit_peak;     // present a peak beat
    logic emit_final;    // present the count beat
    logic next_pixel;    // step to the next pixel in raster order
  } hpf_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic load_last;     // the sample being stored completes the map
    logic below_thr;     // captured centre is below the threshold
    logic greater;       // the window sample just read beats the centre
    logic win_last;      // this window read is the last one
    logic limit_zero;    // peak limit is zero
    logic limit_hit;     // peak count has reached the limit
    logic pix_last;      // current pixel is the last of the map
  } hpf_status_t;

endpackage

FILE: src/hpf_ctrl.sv
// ---------------------------------------------------------------------------
// hpf_ctrl
// Controller of the peak finder: accepts samples while loading, then walks
// the scan one pixel and one window read at a time.
// ---------------------------------------------------------------------------
module hpf_ctrl
  import hpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  hpf_status_t status,
  output hpf_cmd_t    cmd
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PIX   = 3'd1;
  localparam logic [2:0] ST_CENT  = 3'd2;
  localparam logic [2:0] ST_WIN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_NEXT  = 3'd5;
  localparam logic [2:0] ST_FINAL = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_LOAD);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (status.load_last) begin
            cmd.scan_start = 1'b1;
            state_nxt      = status.limit_zero ? ST_FINAL : ST_PIX;
          end
        end
      end
      ST_PIX: begin
        cmd.pix_setup = 1'b1;
        state_nxt     = ST_CENT;
      end
      ST_CENT: begin
        cmd.center_cap = 1'b1;
        state_nxt      = status.below_thr ? ST_NEXT : ST_WIN;
      end
      ST_WIN: begin
        cmd.win_issue = 1'b1;
        if (status.greater) begin
          state_nxt = ST_NEXT;
        end else if (status.win_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last window read compares here
        if (!status.greater) begin
          cmd.emit_peak = 1'b1;
        end
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (status.limit_hit || status.pix_last) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.next_pixel = 1'b1;
          state_nxt      = ST_PIX;
        end
      end
      ST_FINAL: begin
        cmd.emit_final = 1'b1;
        state_nxt      = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

FILE: src/hpf_datapath.sv
// ---------------------------------------------------------------------------
// hpf_datapath
// Map store, load pointer, raster and window counters, the compare unit and
// the registered result beat of the peak finder.
// ---------------------------------------------------------------------------
module hpf_datapath
  import hpf_pkg::*;
#(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hpf_cmd_t                    cmd,
  output hpf_status_t                 status,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic signed [SAMPLE_W-1:0]  threshold,
  input  logic [HALF_W-1:0]           win_half,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] h_dim,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  w_dim,
  input  logic [COUNT_W-1:0]          limit,
  output logic                        out_valid,
  output logic [COORD_W-1:0]          out_peak_row,
  output logic [COORD_W-1:0]          out_peak_col,
  output logic [COUNT_W-1:0]          out_peak_total,
  output logic                        out_last
);

  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT+1);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW + 1;
  localparam int XR    = RW + 4;
  localparam int XC    = CW + 4;

  // map store
  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic [AW-1:0]              rd_addr;

  // load and scan registers
  logic [AW-1:0]              load_pos_r;
  logic [RW-1:0]              i_r;
  logic [CW-1:0]              j_r;
  logic [AW-1:0]              p_r;
  logic [COUNT_W-1:0]         count_r;
  logic [RW-1:0]              ii_r, r1_r;
  logic [CW-1:0]              jj_r, c0_r, c1_r;
  logic [AW-1:0]              rb_r;
  logic signed [SAMPLE_W-1:0] v_r;
  logic                       cmp_v_r;

  // result beat registers
  logic                       out_valid_r;
  logic [COORD_W-1:0]         row_r, col_r;
  logic [COUNT_W-1:0]         total_r;
  logic                       last_r;

  // window bound arithmetic
  logic [XR-1:0] r_lo, r_sum, r_max, r_hi;
  logic [XC-1:0] c_lo, c_sum, c_max, c_hi;
  logic [TW-1:0] map_total;

  assign r_lo  = (XR'(i_r) >= XR'(win_half)) ? XR'(i_r) - XR'(win_half) : '0;
  assign r_sum = XR'(i_r) + XR'(win_half);
  assign r_max = XR'(h_dim) - XR'(1);
  assign r_hi  = (r_sum > r_max) ? r_max : r_sum;
  assign c_lo  = (XC'(j_r) >= XC'(win_half)) ? XC'(j_r) - XC'(win_half) : '0;
  assign c_sum = XC'(j_r) + XC'(win_half);
  assign c_max = XC'(w_dim) - XC'(1);
  assign c_hi  = (c_sum > c_max) ? c_max : c_sum;

  assign map_total = TW'(h_dim) * TW'(w_dim);

  // status towards the controller
  assign status.load_last  = (TW'(load_pos_r) + TW'(1)) >= map_total;
  assign status.below_thr  = rdata_r < threshold;
  assign status.greater    = cmp_v_r && (rdata_r > v_r);
  assign status.win_last   = (ii_r == r1_r) && (jj_r == c1_r);
  assign status.limit_zero = (limit == '0);
  assign status.limit_hit  = (count_r == limit);
  assign status.pix_last   = (HW'(i_r) == h_dim - HW'(1)) && (WW'(j_r) == w_dim - WW'(1));

  // read address: window sample while issuing, centre otherwise
  assign rd_addr = cmd.win_issue ? rb_r + AW'(jj_r) : p_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[load_pos_r] <= in_sample;
    end
    rdata_r <= mem[rd_addr];
  end

  // load pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
    end else if (cmd.load) begin
      load_pos_r <= status.load_last ? '0 : load_pos_r + AW'(1);
    end
  end

  // raster counters and peak count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
    end else if (cmd.scan_start) begin
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
    end else begin
      if (cmd.emit_peak) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (cmd.next_pixel) begin
        p_r <= p_r + AW'(1);
        if (WW'(j_r) == w_dim - WW'(1)) begin
          j_r <= '0;
          i_r <= i_r + RW'(1);
        end else begin
          j_r <= j_r + CW'(1);
        end
      end
    end
  end

  // window walk
  always_ff @(posedge clk) begin
    if (cmd.pix_setup) begin
      ii_r <= RW'(r_lo);
      r1_r <= RW'(r_hi);
      jj_r <= CW'(c_lo);
      c0_r <= CW'(c_lo);
      c1_r <= CW'(c_hi);
      rb_r <= AW'(r_lo) * AW'(w_dim);
    end else if (cmd.win_issue) begin
      if (jj_r == c1_r) begin
        jj_r <= c0_r;
        ii_r <= ii_r + RW'(1);
        rb_r <= rb_r + AW'(w_dim);
      end else begin
        jj_r <= jj_r + CW'(1);
      end
    end
    if (cmd.center_cap) begin
      v_r <= rdata_r;
    end
  end

  // compare stage is valid in the cycle after each window read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.win_issue;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_peak || cmd.emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_peak) begin
      row_r   <= COORD_W'(i_r);
      col_r   <= COORD_W'(j_r);
      total_r <= '0;
      last_r  <= 1'b0;
    end else if (cmd.emit_final) begin
      row_r   <= '0;
      col_r   <= '0;
      total_r <= count_r;
      last_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_peak_row   = row_r;
  assign out_peak_col   = col_r;
  assign out_peak_total = total_r;
  assign out_last       = last_r;

endmodule

FILE: src/heatmap_peak_finder.sv
// ---------------------------------------------------------------------------
// heatmap_peak_finder
// Two-dimensional non-maximum-suppression peak detector over one map.
// ---------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low, in raster order, until
// map_height * map_width have arrived; the last one starts the scan and busy
// stays high until the count beat is out. The scan walks the map pixel by
// pixel through the single read port of the map store, one read per cycle:
// a pixel below the threshold ends at its centre read, a candidate reads each
// sample of its clipped window, fewer if a greater neighbour ends the walk
// early (at most 15 x 15 reads). Each peak beat and the final count beat
// appear on the out_ ports for a single cycle with out_valid high and cannot
// be held off. Configuration must be written only between maps (unchecked).
module heatmap_peak_finder
  import hpf_pkg::*;
#(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_PEAKS  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       out_valid,
  output logic [COORD_W-1:0]         out_peak_row,
  output logic [COORD_W-1:0]         out_peak_col,
  output logic [COUNT_W-1:0]         out_peak_total,
  output logic                       out_last
);

  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int WW = $clog2(MAX_WIDTH+1);

  // clamp a dimension into one to its maximum
  function automatic int clamp_dim(input logic [DIM_CFG_W-1:0] v, input int hi);
    int r;
    r = int'(v);
    if (r < 1) begin
      r = 1;
    end else if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // saturate the peak limit
  function automatic int clamp_peaks(input logic [COUNT_W-1:0] v);
    int r;
    r = int'(v);
    if (r > MAX_PEAKS) begin
      r = MAX_PEAKS;
    end
    return r;
  endfunction

  logic signed [SAMPLE_W-1:0] thr_r;
  logic [WINSZ_W-1:0]         win_r;
  logic [HW-1:0]              h_r;
  logic [WW-1:0]              w_r;
  logic [COUNT_W-1:0]         lim_r;

  hpf_cmd_t    cmd;
  hpf_status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      win_r <= WINDOW_RST;
      h_r   <= HW'(clamp_dim(DIM_RST, MAX_HEIGHT));
      w_r   <= WW'(clamp_dim(DIM_RST, MAX_WIDTH));
      lim_r <= COUNT_W'(clamp_peaks(PEAKS_RST));
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:   thr_r <= cfg_data;
        CFG_WINDOW_SIZE: win_r <= cfg_data[WINSZ_W-1:0];
        CFG_MAP_HEIGHT:  h_r   <= HW'(clamp_dim(cfg_data[DIM_CFG_W-1:0], MAX_HEIGHT));
        CFG_MAP_WIDTH:   w_r   <= WW'(clamp_dim(cfg_data[DIM_CFG_W-1:0], MAX_WIDTH));
        CFG_MAX_PEAKS:   lim_r <= COUNT_W'(clamp_peaks(cfg_data[COUNT_W-1:0]));
        default: ;
      endcase
    end
  end

  // controller
  hpf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // datapath
  hpf_datapath #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_sample      (in_sample),
    .threshold      (thr_r),
    .win_half       (win_r[WINSZ_W-1:1]),
    .h_dim          (h_r),
    .w_dim          (w_r),
    .limit          (lim_r),
    .out_valid      (out_valid),
    .out_peak_row   (out_peak_row),
    .out_peak_col   (out_peak_col),
    .out_peak_total (out_peak_total),
    .out_last       (out_last)
  );

  // result beats never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // the count beat comes out as the block goes idle
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("count beat while still busy");

  // the scan only starts from an accepted sample
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a sample");

  // the reported count never exceeds the limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_peak_total <= lim_r))
    else $error("peak count beyond limit");

endmodule

FILE: tb/peak_nms_check.sv
// ---------------------------------------------------------------------------
// peak_nms_check
// Watches the sample, configuration and peak channels of the heatmap peak
// finder. It keeps its own copy of the map and the registers, predicts the
// peak beats and the count beat of every completed map by non-maximum
// suppression, and compares each result beat with the oldest prediction.
// ---------------------------------------------------------------------------
module peak_nms_check
  import hpf_pkg::*;
#(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_PEAKS  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       out_valid,
  input  logic [COORD_W-1:0]         out_peak_row,
  input  logic [COORD_W-1:0]         out_peak_col,
  input  logic [COUNT_W-1:0]         out_peak_total,
  input  logic                       out_last,
  output int                         fail_count,
  output int                         pending,
  output int                         maps_done,
  output int                         peaks_done
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COUNT_W-1:0] total;
    logic               last;
  } peak_beat_t;

  // own copy of the map and the registers
  logic signed [SAMPLE_W-1:0] heat_mem [MAX_HEIGHT*MAX_WIDTH];
  int unsigned                load_pos;
  logic signed [SAMPLE_W-1:0] thr_reg;
  logic [WINSZ_W-1:0]         win_reg;
  logic [DIM_CFG_W-1:0]       rows_reg;
  logic [DIM_CFG_W-1:0]       cols_reg;
  logic [COUNT_W-1:0]         limit_reg;

  peak_beat_t pending_peaks [$];
  int         fails;
  int         maps_seen;
  int         peaks_seen;

  // raster scan with clipped window; equal neighbours do not suppress
  function automatic void predict_peaks(int rows, int cols);
    int                         limit;
    int                         half;
    int                         found;
    int                         r0;
    int                         r1;
    int                         c0;
    int                         c1;
    logic signed [SAMPLE_W-1:0] centre;
    bit                         is_peak;
    peak_beat_t                 beat;
    limit = (limit_reg > MAX_PEAKS) ? MAX_PEAKS : int'(limit_reg);
    half  = int'(win_reg >> 1);
    found = 0;
    for (int i = 0; i < rows && found < limit; i++) begin
      for (int j = 0; j < cols && found < limit; j++) begin
        centre = heat_mem[i*cols + j];
        if (centre >= thr_reg) begin
          r0 = (i >= half) ? i - half : 0;
          c0 = (j >= half) ? j - half : 0;
          r1 = (i + half + 1 < rows) ? i + half + 1 : rows;
          c1 = (j + half + 1 < cols) ? j + half + 1 : cols;
          is_peak = 1'b1;
          for (int ii = r0; ii < r1; ii++)
            for (int jj = c0; jj < c1; jj++)
              if (heat_mem[ii*cols + jj] > centre) is_peak = 1'b0;
          if (is_peak) begin
            beat.row   = COORD_W'(i);
            beat.col   = COORD_W'(j);
            beat.total = '0;
            beat.last  = 1'b0;
            pending_peaks = {pending_peaks, beat};
            found++;
          end
        end
      end
    end
    // count beat closes the map
    beat.row   = '0;
    beat.col   = '0;
    beat.total = COUNT_W'(found);
    beat.last  = 1'b1;
    pending_peaks = {pending_peaks, beat};
  endfunction

  always @(posedge clk) begin : watch
    peak_beat_t want;
    int         rows;
    int         cols;
    string      exp_s;
    string      got_s;
    if (!rst_n) begin
      load_pos  = 0;
      thr_reg   = THRESHOLD_RST;
      win_reg   = WINDOW_RST;
      rows_reg  = DIM_RST;
      cols_reg  = DIM_RST;
      limit_reg = PEAKS_RST;
      pending_peaks.delete();
    end else begin
      // result beats against the oldest prediction
      if (out_valid) begin
        if (out_last) maps_seen++;
        else peaks_seen++;
        if (pending_peaks.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP)
            $display("%0t: unexpected beat: row %0d col %0d total %0d last %0b",
                     $time, out_peak_row, out_peak_col, out_peak_total, out_last);
        end else begin
          want = pending_peaks.pop_front();
          if (want.row !== out_peak_row || want.col !== out_peak_col ||
              want.total !== out_peak_total || want.last !== out_last) begin
            fails++;
            if (fails <= REPORT_CAP) begin
              exp_s = $sformatf("row %0d col %0d total %0d last %0b",
                                want.row, want.col, want.total, want.last);
              got_s = $sformatf("row %0d col %0d total %0d last %0b",
                                out_peak_row, out_peak_col, out_peak_total, out_last);
              $display("%0t: beat mismatch: expected %s, got %s", $time, exp_s, got_s);
            end
          end
        end
      end

      // sample beat; the last one of the map triggers the scan
      if (start && !busy) begin
        rows = (rows_reg < 1) ? 1 : (rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_reg);
        cols = (cols_reg < 1) ? 1 : (cols_reg > MAX_WIDTH) ? MAX_WIDTH : int'(cols_reg);
        if (load_pos < MAX_HEIGHT*MAX_WIDTH) heat_mem[load_pos] = in_sample;
        load_pos++;
        if (load_pos >= rows*cols) begin
          load_pos = 0;
          predict_peaks(rows, cols);
        end
      end

      // register writes, bits above each width dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD:   thr_reg   = cfg_data;
          CFG_WINDOW_SIZE: win_reg   = cfg_data[WINSZ_W-1:0];
          CFG_MAP_HEIGHT:  rows_reg  = cfg_data[DIM_CFG_W-1:0];
          CFG_MAP_WIDTH:   cols_reg  = cfg_data[DIM_CFG_W-1:0];
          CFG_MAX_PEAKS:   limit_reg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= pending_peaks.size();
    maps_done  <= maps_seen;
    peaks_done <= peaks_seen;
  end

endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Top of the heatmap peak finder bench: clock, reset, sample and register
// stimulus. A single-row map straight out of reset, a short directed set of
// corner maps, then random register settings with random map contents; the
// checker beside the block predicts and compares every peak beat.
// ---------------------------------------------------------------------------
module testbench
  import hpf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    H_MAX        = 64;
  localparam int    W_MAX        = 64;
  localparam int    PEAK_MAX     = 32;
  localparam int    RANDOM_ITEMS = 260;
  localparam int    SAMPLE_MIN   = -32768;
  localparam int    SAMPLE_MAX   = 32767;
  localparam longint TIMEOUT_NS  = 50_000_000;

  // unused register indexes, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  // kinds of map content
  localparam int MIX_RANDOM = 0;
  localparam int MIX_LEVELS = 1;
  localparam int MIX_SPARSE = 2;

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       start          = 1'b0;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] in_sample      = '0;
  logic                       cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index      = '0;
  logic [CFG_DATA_W-1:0]      cfg_data       = '0;
  logic                       out_valid;
  logic [COORD_W-1:0]         out_peak_row;
  logic [COORD_W-1:0]         out_peak_col;
  logic [COUNT_W-1:0]         out_peak_total;
  logic                       out_last;

  int fail_count;
  int pending;
  int maps_done;
  int peaks_done;

  int thr_now    = int'(THRESHOLD_RST);
  int beats_sent = 0;
  bit burst      = 1'b0;

  heatmap_peak_finder #(
    .MAX_HEIGHT(H_MAX),
    .MAX_WIDTH (W_MAX),
    .MAX_PEAKS (PEAK_MAX)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_sample     (in_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_peak_row  (out_peak_row),
    .out_peak_col  (out_peak_col),
    .out_peak_total(out_peak_total),
    .out_last      (out_last)
  );

  peak_nms_check #(
    .MAX_HEIGHT(H_MAX),
    .MAX_WIDTH (W_MAX),
    .MAX_PEAKS (PEAK_MAX)
  ) nms_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_sample     (in_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_peak_row  (out_peak_row),
    .out_peak_col  (out_peak_col),
    .out_peak_total(out_peak_total),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending       (pending),
    .maps_done     (maps_done),
    .peaks_done    (peaks_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample value of the requested kind, shaped around the current threshold
  function automatic logic [SAMPLE_W-1:0] pick_sample(int mix);
    int v;
    int tu;
    tu = thr_now - SAMPLE_MIN;
    case (mix)
      MIX_LEVELS: begin
        case ($urandom_range(5, 0))
          0:       v = thr_now - 1;
          1, 2:    v = thr_now;
          3:       v = thr_now + 1;
          4:       v = SAMPLE_MAX;
          default: v = SAMPLE_MIN;
        endcase
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      end
      MIX_SPARSE: begin
        if (tu == 0 || $urandom_range(7, 0) == 0)
          v = int'($urandom_range(65535, tu)) + SAMPLE_MIN;
        else
          v = int'($urandom_range(tu - 1, 0)) + SAMPLE_MIN;
      end
      default: v = int'($urandom_range(65535, 0)) + SAMPLE_MIN;
    endcase
    return SAMPLE_W'(v);
  endfunction

  // one sample beat, with a random hold-off unless in a burst
  task automatic send_beat(logic [SAMPLE_W-1:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(10, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // a whole map; start is left high so the next map can wait on busy
  task automatic send_map(int rows, int cols, int mix);
    int n;
    n = ((rows < 1) ? 1 : (rows > H_MAX) ? H_MAX : rows) *
        ((cols < 1) ? 1 : (cols > W_MAX) ? W_MAX : cols);
    burst = ($urandom_range(3, 0) == 0);
    for (int k = 0; k < n; k++) send_beat(pick_sample(mix));
  endtask

  // block idle: no beat outstanding, busy low, then a short settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // all registers, junk above each register width
  task automatic configure(int thr, int win, int rows, int cols, int limit);
    logic [CFG_DATA_W-1:0] junk;
    wait_idle();
    junk = CFG_DATA_W'($urandom);
    if ($urandom_range(2, 0) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)), junk);
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_WINDOW_SIZE, {junk[CFG_DATA_W-1:WINSZ_W], WINSZ_W'(win)});
    write_reg(CFG_MAP_HEIGHT, {junk[CFG_DATA_W-1:DIM_CFG_W], DIM_CFG_W'(rows)});
    write_reg(CFG_MAP_WIDTH, {junk[CFG_DATA_W-1:DIM_CFG_W], DIM_CFG_W'(cols)});
    write_reg(CFG_MAX_PEAKS, {junk[CFG_DATA_W-1:COUNT_W], COUNT_W'(limit)});
    cfg_we  <= 1'b0;
    thr_now = thr;
  endtask

  // stimulus
  initial begin
    int thr;
    int win;
    int rows;
    int cols;
    int limit;
    int random_end;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // one row of the reset width, all other registers at reset
    write_reg(CFG_MAP_HEIGHT, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_map(1, W_MAX, MIX_SPARSE);

    // lowest threshold, single pixel, window of the pixel alone
    configure(SAMPLE_MIN, 0, 1, 1, 1);
    send_beat(16'h8000);

    // top threshold, plateau of equal maxima all reported
    configure(SAMPLE_MAX, 3, 2, 3, PEAK_MAX);
    send_beat(16'h7fff);
    send_beat(16'h7fff);
    send_beat(16'h0000);
    send_beat(16'h8000);
    send_beat(16'h7fff);
    send_beat(16'h7fff);

    // peak limit zero with the widest window: count beat only
    configure(0, 15, 3, 3, 0);
    for (int k = 1; k <= 9; k++) send_beat(SAMPLE_W'(k * 1000));

    // zero dimensions read as one, limit above the maximum saturates
    configure(0, 4, 0, 0, 40);
    send_beat(16'hffff);
    send_beat(16'h7fff);

    // even window size, strictly greater neighbour suppresses
    configure(100, 2, 2, 2, 63);
    send_beat(SAMPLE_W'(100));
    send_beat(SAMPLE_W'(99));
    send_beat(SAMPLE_W'(99));
    send_beat(SAMPLE_W'(101));

    // random settings, a few maps each
    random_end = beats_sent + RANDOM_ITEMS;
    while (beats_sent < random_end) begin
      case ($urandom_range(9, 0))
        0, 1:    thr = SAMPLE_MIN;
        2:       thr = SAMPLE_MAX;
        3, 4, 5: thr = int'($urandom_range(4000, 0)) - 2000;
        default: thr = int'($urandom_range(65535, 0)) + SAMPLE_MIN;
      endcase
      win = $urandom_range(15, 0);
      case ($urandom_range(9, 0))
        0: begin
          rows = $urandom_range(127, H_MAX + 1);
          cols = $urandom_range(1, 0);
        end
        1: begin
          rows = $urandom_range(1, 0);
          cols = $urandom_range(127, W_MAX + 1);
        end
        2: begin
          rows = $urandom_range(6, 0);
          cols = 0;
        end
        default: begin
          rows = $urandom_range(6, 1);
          cols = $urandom_range(6, 1);
        end
      endcase
      case ($urandom_range(9, 0))
        0:       limit = 0;
        1:       limit = $urandom_range(63, PEAK_MAX + 1);
        2:       limit = 1;
        default: limit = $urandom_range(PEAK_MAX, 2);
      endcase
      configure(thr, win, rows, cols, limit);
      repeat ($urandom_range(3, 1)) send_map(rows, cols, $urandom_range(MIX_SPARSE, MIX_RANDOM));
    end

    // drain and verdict
    wait_idle();
    repeat (16) @(posedge clk);
    $display("run covered %0d samples over %0d maps with %0d peak beats checked",
             beats_sent, maps_done, peaks_done);
    $display("windows 0 to 15, both threshold extremes, maps from 1x1 up to 64 a side, limits 0 to 63");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timed out with %0d beats outstanding", $time, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
